// ----- hdl/sac_pkg.sv -----
// ----------------------------------------------------------------------------
// sac_pkg
// Types, constants and helper functions shared by the stick aim correction
// block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sac_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [16:0] ONE_FX = 17'h10000;
  localparam logic [16:0] HALF_Q16 = 17'd32768;
  localparam logic [14:0] STICK_FS = 15'd32767;
  localparam logic signed [17:0] STICK_POS = 18'sd32767;
  localparam logic signed [17:0] STICK_NEG = -18'sd32767;
  localparam logic [32:0] DIST_NONE = '1;
  localparam logic [4:0] ITER_LAST = 5'd16;

  localparam logic [1:0] MODE_BOX = 2'd0;
  localparam logic [1:0] MODE_EMPTY = 2'd1;
  localparam logic [1:0] MODE_POLL = 2'd2;

  localparam logic [3:0] CODE_LT = 4'd6;
  localparam logic [3:0] CODE_RT = 4'd7;

  localparam logic [2:0] REG_ACT = 3'd0;
  localparam logic [2:0] REG_MAXC = 3'd1;
  localparam logic [2:0] REG_DECAY = 3'd2;
  localparam logic [2:0] REG_DZ = 3'd3;
  localparam logic [2:0] REG_STALE = 3'd4;
  localparam logic [2:0] REG_THR = 3'd5;

  localparam logic [3:0] RST_ACT = 4'd6;
  localparam logic [16:0] RST_MAXC = 17'd19661;
  localparam logic [16:0] RST_DECAY = 17'd6554;
  localparam logic [16:0] RST_DZ = 17'd3277;
  localparam logic [23:0] RST_STALE = 24'd250000;
  localparam logic [7:0] RST_THR = 8'd30;

  typedef enum logic [4:0] {
    OP_NONE, OP_BOX_PREP, OP_BOX_UPD, OP_EMPTY, OP_POLL_PREP, OP_SQ_X, OP_SQ_Y,
    OP_DZ, OP_SCALE_X, OP_SCALE_Y, OP_CSQ_X, OP_CSQ_Y, OP_MC, OP_SQRT_INIT,
    OP_SQRT_STEP, OP_DIVX_MUL, OP_DIV_INIT, OP_DIV_STEP, OP_DIVX_DONE,
    OP_DIVY_DONE, OP_STK_X, OP_STK_Y, OP_STK_DONE, OP_APPLY, OP_PASS
  } op_e;

  typedef enum logic [5:0] {
    S_IDLE, S_DROP, S_EMPTY, S_BOX_PREP, S_BOX_SQX, S_BOX_SQY, S_BOX_UPD,
    S_POLL_PREP, S_SQX, S_SQY, S_DZ, S_DZ_CHK, S_SCX, S_SCY, S_CSQX, S_CSQY,
    S_MC, S_MC_CHK, S_SQRT_INIT, S_SQRT, S_DIVX_MUL, S_DIVX_INIT, S_DIVX,
    S_DIVX_DONE, S_DIVY_INIT, S_DIVY, S_DIVY_DONE, S_STKX, S_STKY, S_STK_DONE,
    S_APPLY, S_PASS
  } state_e;

  typedef struct packed {
    logic load;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic box_skip;
    logic go;
    logic dz_fail;
    logic cm_over;
    logic cnt_zero;
    logic out_free;
  } sts_t;

  function automatic logic [15:0] btn_mask(input logic [3:0] code);
    logic [15:0] m;
    unique case (code)
      4'd0: m = 16'h1000;
      4'd1: m = 16'h2000;
      4'd2: m = 16'h4000;
      4'd3: m = 16'h8000;
      4'd4: m = 16'h0100;
      4'd5: m = 16'h0200;
      4'd8: m = 16'h0020;
      4'd9: m = 16'h0010;
      4'd10: m = 16'h0040;
      4'd11: m = 16'h0080;
      4'd12: m = 16'h0001;
      4'd13: m = 16'h0002;
      4'd14: m = 16'h0004;
      4'd15: m = 16'h0008;
      default: m = 16'h0000;
    endcase
    return m;
  endfunction

  function automatic logic [16:0] clamp_one(input logic [16:0] v);
    return (v > ONE_FX) ? ONE_FX : v;
  endfunction

  function automatic logic [16:0] off_mag(input logic [16:0] c);
    return (c >= HALF_Q16) ? (c - HALF_Q16) : (HALF_Q16 - c);
  endfunction

  function automatic logic [15:0] sat_stick(input logic signed [17:0] v);
    logic signed [17:0] r;
    priority if (v > STICK_POS) r = STICK_POS;
    else if (v < STICK_NEG) r = STICK_NEG;
    else r = v;
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/sac_ctrl.sv -----
// ----------------------------------------------------------------------------
// sac_ctrl
// Sequencer that steps the datapath through box, frame and poll handling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sac_ctrl
  import sac_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] mode_i,
  input  sts_t       sts_i,
  output logic       in_stall_o,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o.load = 1'b0;
    cmd_o.op = OP_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (mode_i)
            MODE_BOX: state_d = S_BOX_PREP;
            MODE_EMPTY: state_d = S_EMPTY;
            MODE_POLL: state_d = S_POLL_PREP;
            default: state_d = S_DROP;
          endcase
        end
      end
      S_DROP: state_d = S_IDLE;
      S_EMPTY: begin
        cmd_o.op = OP_EMPTY;
        state_d = S_IDLE;
      end
      S_BOX_PREP: begin
        if (sts_i.box_skip) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.op = OP_BOX_PREP;
          state_d = S_BOX_SQX;
        end
      end
      S_BOX_SQX: begin
        cmd_o.op = OP_SQ_X;
        state_d = S_BOX_SQY;
      end
      S_BOX_SQY: begin
        cmd_o.op = OP_SQ_Y;
        state_d = S_BOX_UPD;
      end
      S_BOX_UPD: begin
        cmd_o.op = OP_BOX_UPD;
        state_d = S_IDLE;
      end
      S_POLL_PREP: begin
        cmd_o.op = OP_POLL_PREP;
        state_d = sts_i.go ? S_SQX : S_PASS;
      end
      S_SQX: begin
        cmd_o.op = OP_SQ_X;
        state_d = S_SQY;
      end
      S_SQY: begin
        cmd_o.op = OP_SQ_Y;
        state_d = S_DZ;
      end
      S_DZ: begin
        cmd_o.op = OP_DZ;
        state_d = S_DZ_CHK;
      end
      S_DZ_CHK: state_d = sts_i.dz_fail ? S_PASS : S_SCX;
      S_SCX: begin
        cmd_o.op = OP_SCALE_X;
        state_d = S_SCY;
      end
      S_SCY: begin
        cmd_o.op = OP_SCALE_Y;
        state_d = S_CSQX;
      end
      S_CSQX: begin
        cmd_o.op = OP_CSQ_X;
        state_d = S_CSQY;
      end
      S_CSQY: begin
        cmd_o.op = OP_CSQ_Y;
        state_d = S_MC;
      end
      S_MC: begin
        cmd_o.op = OP_MC;
        state_d = S_MC_CHK;
      end
      S_MC_CHK: state_d = sts_i.cm_over ? S_SQRT_INIT : S_STKX;
      S_SQRT_INIT: begin
        cmd_o.op = OP_SQRT_INIT;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        if (sts_i.cnt_zero) state_d = S_DIVX_MUL;
      end
      S_DIVX_MUL: begin
        cmd_o.op = OP_DIVX_MUL;
        state_d = S_DIVX_INIT;
      end
      S_DIVX_INIT: begin
        cmd_o.op = OP_DIV_INIT;
        state_d = S_DIVX;
      end
      S_DIVX: begin
        cmd_o.op = OP_DIV_STEP;
        if (sts_i.cnt_zero) state_d = S_DIVX_DONE;
      end
      S_DIVX_DONE: begin
        cmd_o.op = OP_DIVX_DONE;
        state_d = S_DIVY_INIT;
      end
      S_DIVY_INIT: begin
        cmd_o.op = OP_DIV_INIT;
        state_d = S_DIVY;
      end
      S_DIVY: begin
        cmd_o.op = OP_DIV_STEP;
        if (sts_i.cnt_zero) state_d = S_DIVY_DONE;
      end
      S_DIVY_DONE: begin
        cmd_o.op = OP_DIVY_DONE;
        state_d = S_STKX;
      end
      S_STKX: begin
        cmd_o.op = OP_STK_X;
        state_d = S_STKY;
      end
      S_STKY: begin
        cmd_o.op = OP_STK_Y;
        state_d = S_STK_DONE;
      end
      S_STK_DONE: begin
        cmd_o.op = OP_STK_DONE;
        state_d = S_APPLY;
      end
      S_APPLY: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_APPLY;
          state_d = S_IDLE;
        end
      end
      S_PASS: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_PASS;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/sac_dp.sv -----
// ----------------------------------------------------------------------------
// sac_dp
// Datapath: block state, one shared multiplier, square root and divide
// iterations, and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sac_dp
  import sac_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [15:0]        box_x_i,
  input  logic [15:0]        box_y_i,
  input  logic [15:0]        box_w_i,
  input  logic [15:0]        box_h_i,
  input  logic               frame_last_i,
  input  logic [31:0]        frame_seq_i,
  input  logic [47:0]        time_us_i,
  input  logic [15:0]        buttons_i,
  input  logic [15:0]        triggers_i,
  input  logic signed [15:0] stick_x_i,
  input  logic signed [15:0] stick_y_i,
  input  logic [3:0]         act_i,
  input  logic [16:0]        maxc_i,
  input  logic [16:0]        decay_i,
  input  logic [16:0]        dz_i,
  input  logic [23:0]        stale_i,
  input  logic [7:0]         thr_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic signed [15:0] out_stick_x_o,
  output logic signed [15:0] out_stick_y_o,
  output logic               assist_applied_o
);

  logic [15:0] bx_q, by_q, bw_q, bh_q, btn_q, trg_q;
  logic        last_q;
  logic [31:0] seq_q;
  logic [47:0] now_q;
  logic signed [15:0] sx_q, sy_q;

  logic [32:0] best_dist_q;
  logic [16:0] best_cx_q, best_cy_q, tgt_cx_q, tgt_cy_q;
  logic [47:0] tgt_time_q, last_poll_q;
  logic        have_tgt_q, was_held_q;
  logic [16:0] strength_q;
  logic [31:0] last_seq_q;

  logic [16:0] oxm_q, oym_q, s_q, cxm_q, cym_q, root_q, dq_q, drem_q;
  logic        sgx_q, sgy_q;
  logic [14:0] dxm_q, dym_q;
  logic [33:0] prod_q, acc_q, sqv_q;
  logic [18:0] srem_q;
  logic [4:0]  cnt_q;

  logic        out_valid_q, res_app_q;
  logic [15:0] res_x_q, res_y_q;

  logic [16:0] mul_a, mul_b;
  logic        mul_en;
  logic [16:0] bcx, bcy, dz_c, mc_c, dec_c, s_start, s_next;
  logic        best_none, seq_rep, held, fresh;
  logic signed [49:0] age;
  logic [33:0] d2;
  logic        upd;
  logic [16:0] nbx, nby;
  logic [20:0] rem_n, trial;
  logic        sq_ge, dv_ge;
  logic [17:0] drn;
  logic signed [17:0] sum_x, sum_y, dxs, dys;

  assign best_none = (best_dist_q == DIST_NONE);
  assign seq_rep = (seq_q != 32'd0) && (seq_q == last_seq_q);
  assign bcx = {1'b0, bx_q} + {2'b0, bw_q[15:1]};
  assign bcy = {1'b0, by_q} + {2'b0, bh_q[15:1]};
  assign dz_c = clamp_one(dz_i);
  assign mc_c = clamp_one(maxc_i);
  assign dec_c = clamp_one(decay_i);
  assign s_start = was_held_q ? strength_q : ONE_FX;
  assign s_next = (s_start >= dec_c) ? (s_start - dec_c) : 17'd0;

  always_comb begin
    priority if (act_i == CODE_LT) held = (trg_q[7:0] >= thr_i);
    else if (act_i == CODE_RT) held = (trg_q[15:8] >= thr_i);
    else held = ((btn_q & btn_mask(act_i)) != 16'd0);
  end

  assign age = $signed({2'b00, now_q}) - $signed({2'b00, tgt_time_q});
  assign fresh = have_tgt_q &&
                 !((tgt_time_q != 48'd0) && (age > $signed({26'd0, stale_i})));

  assign d2 = acc_q + prod_q;
  assign upd = (d2 < {1'b0, best_dist_q});
  assign nbx = upd ? bcx : best_cx_q;
  assign nby = upd ? bcy : best_cy_q;

  assign rem_n = {srem_q, sqv_q[33:32]};
  assign trial = {2'b00, root_q, 2'b01};
  assign sq_ge = (rem_n >= trial);
  assign drn = {drem_q, dq_q[16]};
  assign dv_ge = (drn >= {1'b0, root_q});

  assign dxs = sgx_q ? -$signed({3'b000, dxm_q}) : $signed({3'b000, dxm_q});
  assign dys = sgy_q ? $signed({3'b000, dym_q}) : -$signed({3'b000, dym_q});
  assign sum_x = $signed({{2{sx_q[15]}}, sx_q}) + dxs;
  assign sum_y = $signed({{2{sy_q[15]}}, sy_q}) + dys;

  always_comb begin
    mul_en = 1'b1;
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_SQ_X: begin mul_a = oxm_q; mul_b = oxm_q; end
      OP_SQ_Y: begin mul_a = oym_q; mul_b = oym_q; end
      OP_DZ: begin mul_a = dz_c; mul_b = dz_c; end
      OP_SCALE_X: begin mul_a = oxm_q; mul_b = s_q; end
      OP_SCALE_Y: begin mul_a = oym_q; mul_b = s_q; end
      OP_CSQ_X: begin mul_a = cxm_q; mul_b = cxm_q; end
      OP_CSQ_Y: begin mul_a = cym_q; mul_b = cym_q; end
      OP_MC: begin mul_a = mc_c; mul_b = mc_c; end
      OP_DIVX_MUL: begin mul_a = cxm_q; mul_b = mc_c; end
      OP_DIVX_DONE: begin mul_a = cym_q; mul_b = mc_c; end
      OP_STK_X: begin mul_a = cxm_q; mul_b = {2'b00, STICK_FS}; end
      OP_STK_Y: begin mul_a = cym_q; mul_b = {2'b00, STICK_FS}; end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bx_q <= box_x_i;
      by_q <= box_y_i;
      bw_q <= box_w_i;
      bh_q <= box_h_i;
      last_q <= frame_last_i;
      seq_q <= frame_seq_i;
      now_q <= time_us_i;
      btn_q <= buttons_i;
      trg_q <= triggers_i;
      sx_q <= stick_x_i;
      sy_q <= stick_y_i;
    end
    if (mul_en) prod_q <= mul_a * mul_b;
    unique case (cmd_i.op)
      OP_BOX_PREP: begin
        oxm_q <= off_mag(bcx);
        oym_q <= off_mag(bcy);
      end
      OP_POLL_PREP: begin
        oxm_q <= off_mag(tgt_cx_q);
        oym_q <= off_mag(tgt_cy_q);
        sgx_q <= (tgt_cx_q < HALF_Q16);
        sgy_q <= (tgt_cy_q < HALF_Q16);
        s_q <= s_start;
      end
      OP_SQ_Y, OP_CSQ_Y: acc_q <= prod_q;
      OP_DZ, OP_MC: acc_q <= d2;
      OP_SCALE_Y: cxm_q <= prod_q[FRAC_BITS +: 17];
      OP_CSQ_X: cym_q <= prod_q[FRAC_BITS +: 17];
      OP_SQRT_INIT: begin
        sqv_q <= acc_q;
        srem_q <= '0;
        root_q <= '0;
        cnt_q <= ITER_LAST;
      end
      OP_SQRT_STEP: begin
        sqv_q <= {sqv_q[31:0], 2'b00};
        srem_q <= sq_ge ? 19'(rem_n - trial) : rem_n[18:0];
        root_q <= {root_q[15:0], sq_ge};
        cnt_q <= cnt_q - 5'd1;
      end
      OP_DIV_INIT: begin
        drem_q <= prod_q[33:17];
        dq_q <= prod_q[16:0];
        cnt_q <= ITER_LAST;
      end
      OP_DIV_STEP: begin
        drem_q <= dv_ge ? 17'(drn - {1'b0, root_q}) : drn[16:0];
        dq_q <= {dq_q[15:0], dv_ge};
        cnt_q <= cnt_q - 5'd1;
      end
      OP_DIVX_DONE: cxm_q <= dq_q;
      OP_DIVY_DONE: cym_q <= dq_q;
      OP_STK_Y: dxm_q <= prod_q[FRAC_BITS +: 15];
      OP_STK_DONE: dym_q <= prod_q[FRAC_BITS +: 15];
      OP_APPLY: begin
        res_x_q <= sat_stick(sum_x);
        res_y_q <= sat_stick(sum_y);
        res_app_q <= 1'b1;
      end
      OP_PASS: begin
        res_x_q <= sx_q;
        res_y_q <= sy_q;
        res_app_q <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_dist_q <= DIST_NONE;
      best_cx_q <= '0;
      best_cy_q <= '0;
      tgt_cx_q <= '0;
      tgt_cy_q <= '0;
      tgt_time_q <= '0;
      have_tgt_q <= 1'b0;
      strength_q <= '0;
      was_held_q <= 1'b0;
      last_seq_q <= '0;
      last_poll_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_APPLY || cmd_i.op == OP_PASS) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_BOX_PREP: begin
          if (best_none) last_seq_q <= seq_q;
        end
        OP_BOX_UPD: begin
          if (last_q) begin
            tgt_cx_q <= nbx;
            tgt_cy_q <= nby;
            tgt_time_q <= (now_q != 48'd0) ? now_q : last_poll_q;
            have_tgt_q <= 1'b1;
            best_dist_q <= DIST_NONE;
          end else if (upd) begin
            best_dist_q <= d2[32:0];
          end
          best_cx_q <= nbx;
          best_cy_q <= nby;
        end
        OP_EMPTY: begin
          best_dist_q <= DIST_NONE;
          if (!seq_rep) begin
            have_tgt_q <= 1'b0;
            last_seq_q <= seq_q;
          end
        end
        OP_POLL_PREP: begin
          last_poll_q <= now_q;
          strength_q <= held ? s_next : 17'd0;
          was_held_q <= held;
        end
        default: ;
      endcase
    end
  end

  assign sts_o.box_skip = best_none && seq_rep;
  assign sts_o.go = held && fresh && (s_start != 17'd0);
  assign sts_o.dz_fail = (acc_q < prod_q);
  assign sts_o.cm_over = (acc_q > prod_q);
  assign sts_o.cnt_zero = (cnt_q == 5'd0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_stick_x_o = res_x_q;
  assign out_stick_y_o = res_y_q;
  assign assist_applied_o = res_app_q;

endmodule

`default_nettype wire

// ----- hdl/stick_aim_correction.sv -----
// ----------------------------------------------------------------------------
// stick_aim_correction
// Aim assist that adds a vector toward the detection nearest the screen
// center to the right stick of each controller poll.
// ----------------------------------------------------------------------------
// One item is handled at a time. A poll takes least time when no correction
// is made and most when the correction is limited to the configured maximum
// length. The long case is set by the square root and the two divides, each
// run one result bit per cycle, and by the single shared multiplier that every
// product goes through. A finished result sits in an output register, so the
// next item is taken while it waits for its transfer.
`timescale 1ns / 1ps
`default_nettype none

module stick_aim_correction
  import sac_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [15:0]        box_x_i,
  input  logic [15:0]        box_y_i,
  input  logic [15:0]        box_w_i,
  input  logic [15:0]        box_h_i,
  input  logic               frame_last_i,
  input  logic [31:0]        frame_seq_i,
  input  logic [47:0]        time_us_i,
  input  logic [15:0]        buttons_i,
  input  logic [15:0]        triggers_i,
  input  logic signed [15:0] stick_x_i,
  input  logic signed [15:0] stick_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] out_stick_x_o,
  output logic signed [15:0] out_stick_y_o,
  output logic               assist_applied_o
);

  logic [3:0]  act_q;
  logic [16:0] maxc_q, decay_q, dz_q;
  logic [23:0] stale_q;
  logic [7:0]  thr_q;
  logic [2:0]  reg_idx;
  logic        wr_en;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= RST_ACT;
      maxc_q <= RST_MAXC;
      decay_q <= RST_DECAY;
      dz_q <= RST_DZ;
      stale_q <= RST_STALE;
      thr_q <= RST_THR;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ACT: act_q <= pwdata[3:0];
        REG_MAXC: maxc_q <= pwdata[16:0];
        REG_DECAY: decay_q <= pwdata[16:0];
        REG_DZ: dz_q <= pwdata[16:0];
        REG_STALE: stale_q <= pwdata[23:0];
        REG_THR: thr_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACT: prdata = {28'd0, act_q};
      REG_MAXC: prdata = {15'd0, maxc_q};
      REG_DECAY: prdata = {15'd0, decay_q};
      REG_DZ: prdata = {15'd0, dz_q};
      REG_STALE: prdata = {8'd0, stale_q};
      REG_THR: prdata = {24'd0, thr_q};
      default: prdata = 32'd0;
    endcase
  end

  sac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  sac_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .box_x_i          (box_x_i),
    .box_y_i          (box_y_i),
    .box_w_i          (box_w_i),
    .box_h_i          (box_h_i),
    .frame_last_i     (frame_last_i),
    .frame_seq_i      (frame_seq_i),
    .time_us_i        (time_us_i),
    .buttons_i        (buttons_i),
    .triggers_i       (triggers_i),
    .stick_x_i        (stick_x_i),
    .stick_y_i        (stick_y_i),
    .act_i            (act_q),
    .maxc_i           (maxc_q),
    .decay_i          (decay_q),
    .dz_i             (dz_q),
    .stale_i          (stale_q),
    .thr_i            (thr_q),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .out_stick_x_o    (out_stick_x_o),
    .out_stick_y_o    (out_stick_y_o),
    .assist_applied_o (assist_applied_o)
  );

endmodule

`default_nettype wire

// ----- hdl/sac_checker.sv -----
// ----------------------------------------------------------------------------
// sac_checker
// Port-level checks for the stick aim correction block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sac_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] out_stick_x_o,
  input logic signed [15:0] out_stick_y_o,
  input logic               assist_applied_o
);

  // An item is handled alone, so the input stalls right after each transfer.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a transfer");

  a_applied_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && assist_applied_o |->
      out_stick_x_o != -16'sd32768 && out_stick_y_o != -16'sd32768)
    else $error("corrected stick outside the saturation range");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(out_stick_x_o) && $stable(out_stick_y_o) && $stable(assist_applied_o))
    else $error("stalled result changed");

endmodule

bind stick_aim_correction sac_checker u_sac_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .out_stick_x_o    (out_stick_x_o),
  .out_stick_y_o    (out_stick_y_o),
  .assist_applied_o (assist_applied_o)
);

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stick_aim_correction. Frames of detection boxes,
// empty frames, controller polls and stray items are sent through the input
// channel. A scoreboard predicts each poll result and compares it with the
// output transfers. Several register settings and idling mixes are covered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sac_pkg::*;

  localparam int  RUN_LIMIT = 3000000;
  localparam int  SETTLE    = 120;
  localparam longint NO_BOX = 64'h1_FFFF_FFFF;
  localparam logic [15:0] BTN_MASK [16] = '{
    16'h1000, 16'h2000, 16'h4000, 16'h8000, 16'h0100, 16'h0200, 16'h0000, 16'h0000,
    16'h0020, 16'h0010, 16'h0040, 16'h0080, 16'h0001, 16'h0002, 16'h0004, 16'h0008};

  typedef struct {
    logic [1:0]         mode;
    logic [15:0]        bx, by, bw, bh;
    logic               last;
    logic [31:0]        seq;
    logic [47:0]        t;
    logic [15:0]        btn, trg;
    logic signed [15:0] sx, sy;
  } item_t;

  typedef struct {
    logic [15:0] x, y;
    logic        applied;
  } stick_res_t;

  class stick_scoreboard;
    stick_res_t pending_q[$];
    int         errors;
    longint     act, maxc, decay, dz, stale, thr;
    longint     best_d, best_x, best_y, tgt_x, tgt_y, tgt_t, strength, last_seq, last_poll;
    bit         have_tgt, held_prev;

    function new();
      act = RST_ACT; maxc = RST_MAXC; decay = RST_DECAY; dz = RST_DZ;
      stale = RST_STALE; thr = RST_THR;
      best_d = NO_BOX; best_x = 0; best_y = 0; tgt_x = 0; tgt_y = 0; tgt_t = 0;
      strength = 0; last_seq = 0; last_poll = 0; have_tgt = 0; held_prev = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, longint v);
      case (idx)
        REG_ACT:   act = v & 15;
        REG_MAXC:  maxc = v & 17'h1FFFF;
        REG_DECAY: decay = v & 17'h1FFFF;
        REG_DZ:    dz = v & 17'h1FFFF;
        REG_STALE: stale = v & 24'hFFFFFF;
        REG_THR:   thr = v & 8'hFF;
        default: ;
      endcase
    endfunction

    function longint lim_one(longint v);
      return (v > longint'(ONE_FX)) ? longint'(ONE_FX) : v;
    endfunction

    function longint scale_trunc(longint v, longint num, longint den);
      longint m;
      m = (v < 0) ? -v : v;
      m = m * num / den;
      return (v < 0) ? -m : m;
    endfunction

    function longint floor_sqrt(longint v);
      longint r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint sat(longint v);
      if (v > 32767) return 32767;
      if (v < -32767) return -32767;
      return v;
    endfunction

    function bit seq_fresh(longint s);
      if (s != 0 && s == last_seq) return 0;
      last_seq = s;
      return 1;
    endfunction

    function bit trigger_held(item_t it);
      if (act == CODE_LT) return it.trg[7:0] >= thr;
      if (act == CODE_RT) return it.trg[15:8] >= thr;
      return (it.btn & BTN_MASK[act]) != 0;
    endfunction

    function void note_input(item_t it);
      longint cx, cy, dx, dy, ox, oy, mc, r, sx, sy, ox_out, oy_out, s, dzc;
      stick_res_t e;
      bit applied, fresh;
      applied = 0;
      case (it.mode)
        MODE_BOX: begin
          if (best_d == NO_BOX && !seq_fresh(it.seq)) return;
          cx = it.bx + (it.bw >> 1);
          cy = it.by + (it.bh >> 1);
          dx = cx - 32768;
          dy = cy - 32768;
          if (dx * dx + dy * dy < best_d) begin
            best_d = dx * dx + dy * dy;
            best_x = cx;
            best_y = cy;
          end
          if (it.last) begin
            tgt_x = best_x;
            tgt_y = best_y;
            tgt_t = (it.t != 0) ? longint'(it.t) : last_poll;
            have_tgt = 1;
            best_d = NO_BOX;
          end
        end
        MODE_EMPTY: begin
          best_d = NO_BOX;
          if (seq_fresh(it.seq)) have_tgt = 0;
        end
        MODE_POLL: begin
          last_poll = it.t;
          sx = it.sx;
          sy = it.sy;
          ox_out = sx;
          oy_out = sy;
          if (!trigger_held(it)) begin
            strength = 0;
            held_prev = 0;
          end else begin
            if (!held_prev) strength = ONE_FX;
            held_prev = 1;
            s = strength;
            strength = strength - lim_one(decay);
            if (strength < 0) strength = 0;
            fresh = have_tgt;
            if (fresh && tgt_t != 0 && longint'(it.t) - tgt_t > stale) fresh = 0;
            if (fresh && s > 0) begin
              ox = tgt_x - 32768;
              oy = tgt_y - 32768;
              dzc = lim_one(dz);
              if (ox * ox + oy * oy >= dzc * dzc) begin
                mc = lim_one(maxc);
                cx = scale_trunc(ox, s, ONE_FX);
                cy = scale_trunc(oy, s, ONE_FX);
                if (cx * cx + cy * cy > mc * mc) begin
                  r = floor_sqrt(cx * cx + cy * cy);
                  cx = scale_trunc(cx, mc, r);
                  cy = scale_trunc(cy, mc, r);
                end
                ox_out = sat(sx + scale_trunc(cx, STICK_FS, ONE_FX));
                oy_out = sat(sy - scale_trunc(cy, STICK_FS, ONE_FX));
                applied = 1;
              end
            end
          end
          e.x = ox_out[15:0];
          e.y = oy_out[15:0];
          e.applied = applied;
          pending_q.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [15:0] x, logic [15:0] y, logic a);
      stick_res_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d applied=%0b", $time,
                 $signed(x), $signed(y), a);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (x !== e.x) begin
        $display("%0t: out_stick_x expected %0d got %0d", $time, $signed(e.x), $signed(x));
        errors++;
      end
      if (y !== e.y) begin
        $display("%0t: out_stick_y expected %0d got %0d", $time, $signed(e.y), $signed(y));
        errors++;
      end
      if (a !== e.applied) begin
        $display("%0t: assist_applied expected %0b got %0b", $time, e.applied, a);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i = MODE_POLL;
  logic [15:0]        box_x_i = '0, box_y_i = '0, box_w_i = '0, box_h_i = '0;
  logic               frame_last_i = 1'b0;
  logic [31:0]        frame_seq_i = '0;
  logic [47:0]        time_us_i = '0;
  logic [15:0]        buttons_i = '0, triggers_i = '0;
  logic signed [15:0] stick_x_i = '0, stick_y_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] out_stick_x_o, out_stick_y_o;
  logic               assist_applied_o;

  stick_scoreboard sb = new();
  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;
  int          hold_off = 0;
  int          cycles = 0;
  logic [47:0] now_us = 48'd1000;
  logic [31:0] seq_ctr = 32'd100;

  stick_aim_correction u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .mode_i(mode_i), .box_x_i(box_x_i), .box_y_i(box_y_i), .box_w_i(box_w_i),
    .box_h_i(box_h_i), .frame_last_i(frame_last_i), .frame_seq_i(frame_seq_i),
    .time_us_i(time_us_i), .buttons_i(buttons_i), .triggers_i(triggers_i),
    .stick_x_i(stick_x_i), .stick_y_i(stick_y_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_stick_x_o(out_stick_x_o), .out_stick_y_o(out_stick_y_o),
    .assist_applied_o(assist_applied_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      out_stall_i <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(out_stick_x_o, out_stick_y_o, assist_applied_o);
  end

  function automatic item_t blank(logic [1:0] m);
    item_t it;
    it.mode = m; it.bx = 16'd32768; it.by = 16'd32768; it.bw = '0; it.bh = '0;
    it.last = 1'b1; it.seq = '0; it.t = now_us; it.btn = '0; it.trg = 16'hFFFF;
    it.sx = '0; it.sy = '0;
    return it;
  endfunction

  task automatic send(item_t it);
    mode_i <= it.mode; box_x_i <= it.bx; box_y_i <= it.by; box_w_i <= it.bw;
    box_h_i <= it.bh; frame_last_i <= it.last; frame_seq_i <= it.seq;
    time_us_i <= it.t; buttons_i <= it.btn; triggers_i <= it.trg;
    stick_x_i <= it.sx; stick_y_i <= it.sy;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic write_all(int a, int mc, int dc, int dzv, int st, int th);
    write_reg(REG_ACT, a);
    write_reg(REG_MAXC, mc);
    write_reg(REG_DECAY, dc);
    write_reg(REG_DZ, dzv);
    write_reg(REG_STALE, st);
    write_reg(REG_THR, th);
  endtask

  function automatic item_t rand_box(logic [31:0] s, logic [47:0] t, logic l);
    item_t it;
    it = blank(MODE_BOX);
    if ($urandom_range(9) < 7) begin
      it.bx = $urandom_range(16000, 44000); it.by = $urandom_range(16000, 44000);
      it.bw = $urandom_range(0, 12000);     it.bh = $urandom_range(0, 12000);
    end else begin
      it.bx = $urandom; it.by = $urandom; it.bw = $urandom; it.bh = $urandom;
    end
    it.seq = s; it.t = t; it.last = l;
    it.btn = $urandom; it.trg = $urandom; it.sx = $urandom; it.sy = $urandom;
    return it;
  endfunction

  function automatic item_t rand_poll();
    item_t it;
    it = blank(MODE_POLL);
    it.t = now_us; it.sx = $urandom; it.sy = $urandom;
    it.bx = $urandom; it.seq = $urandom;
    it.btn = $urandom;
    it.trg = $urandom;
    if ($urandom_range(9) < 8) begin
      it.btn = it.btn | BTN_MASK[sb.act];
      it.trg = ($urandom_range(3) == 0) ? 16'hFFFF : (it.trg | 16'h8080);
    end
    return it;
  endfunction

  task automatic random_burst(inout int n);
    item_t it;
    int r, k, nb;
    logic [31:0] s;
    logic [47:0] t;
    r = $urandom_range(99);
    if (r < 40) begin
      nb = $urandom_range(1, 4);
      s = seq_ctr;
      if ($urandom_range(9) != 0) begin
        if ($urandom_range(19) == 0) begin
          s = 0;
        end else begin
          seq_ctr = seq_ctr + 32'd1;
          s = seq_ctr;
        end
      end
      if ($urandom_range(29) == 0) s = $urandom;
      t = ($urandom_range(14) == 0) ? 48'd0 : now_us - $urandom_range(0, 30000);
      for (k = 0; k < nb; k++) begin
        it = rand_box(s, t, (k == nb - 1) && ($urandom_range(19) != 0));
        send(it);
        n++;
      end
    end else if (r < 48) begin
      it = blank(MODE_EMPTY);
      if ($urandom_range(3) == 0) begin
        it.seq = seq_ctr;
      end else begin
        seq_ctr = seq_ctr + 32'd1;
        it.seq = seq_ctr;
      end
      it.bx = $urandom; it.btn = $urandom; it.sx = $urandom;
      send(it);
      n++;
    end else if (r < 53) begin
      it = rand_box($urandom, {$urandom, $urandom}, $urandom);
      it.mode = ($urandom_range(1) == 0) ? 2'd3 : 2'($urandom);
      send(it);
      n++;
    end else begin
      nb = $urandom_range(1, 4);
      for (k = 0; k < nb; k++) begin
        if ($urandom_range(49) == 0) now_us = {$urandom, $urandom};
        else now_us = now_us + $urandom_range(0, 90000);
        send(rand_poll());
        n++;
      end
    end
  endtask

  task automatic directed();
    item_t it;
    send(blank(MODE_POLL));
    it = blank(2'd3); it.bx = '1; send(it);
    it = blank(MODE_BOX); it.bx = 0; it.by = 0; it.bw = 0; it.bh = 0;
    it.last = 0; it.seq = 5; send(it);
    it = blank(MODE_BOX); it.bx = '1; it.by = '1; it.bw = '1; it.bh = '1;
    it.seq = 5; it.t = 48'hFFFF_FFFF_FFFF; send(it);
    it = blank(MODE_POLL); it.sx = 16'sh7FFF; it.sy = 16'sh8000; send(it);
    it = blank(MODE_POLL); it.sx = 16'sh8000; it.sy = 16'sh7FFF; send(it);
    it = blank(MODE_EMPTY); it.seq = 5; send(it);
    it = blank(MODE_BOX); it.seq = 5; it.bx = 0; send(it);
    it = blank(MODE_BOX); it.seq = 0; it.t = 0; send(it);
    send(blank(MODE_POLL));
    it = blank(MODE_BOX); it.seq = 6; it.last = 0; it.bx = 1000; send(it);
    it = blank(MODE_EMPTY); it.seq = 7; send(it);
    send(blank(MODE_POLL));
    it = blank(MODE_BOX); it.seq = 8; it.bx = 60000; it.by = 1000; it.t = 2000; send(it);
    it = blank(MODE_POLL); it.t = 2000 + 300000; send(it);
    it = blank(MODE_POLL); it.t = 2500; send(it);
    it = blank(MODE_POLL); it.trg = 16'h0000; send(it);
    it = blank(MODE_POLL); it.t = 2600; send(it);
  endtask

  initial begin
    int n, ph;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    for (ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: write_all(CODE_LT, RST_MAXC, RST_DECAY, RST_DZ, RST_STALE, RST_THR);
        1: write_all($urandom_range(0, 15), 65536, 0, 0, 24'hFFFFFF, 0);
        2: write_all(CODE_RT, 0, 65536, 65536, 0, 255);
        3: write_all($urandom_range(0, 15), $urandom_range(0, 65536),
                     $urandom_range(0, 20000), $urandom_range(0, 8000),
                     $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 255));
        default: write_all(0, 40000, 3000, 1000, 500000, 128);
      endcase
      snd_idle_pct = (ph == 1) ? 82 : (ph == 3) ? 22 : 0;
      rcv_stall_pct = (ph == 2) ? 82 : (ph == 3) ? 22 : 0;
      n = 0;
      while (n < 300) begin
        if (ph == 0 && n >= 100 && n < 104) begin
          hold_off <= 400;
          n = 104;
        end
        if (ph == 3 && n >= 150 && n < 154) begin
          in_valid_i <= 1'b0;
          while (sb.pending_q.size() != 0) @(posedge clk_i);
          n = 154;
        end
        random_burst(n);
      end
    end
    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
